// ----- design/gbe_pkg.sv -----
// ----------------------------------------------------------------------------
// gbe_pkg
// shared widths, contact mode codes and the state record of the backlash
// estimator
// ----------------------------------------------------------------------------
`default_nettype none

package gbe_pkg;

    localparam int STEP_W   = 16;
    localparam int WHEEL_W  = STEP_W + 1;
    localparam int PLAY_W   = 15;
    localparam int HYST_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 15;

    // internal arithmetic width, wide enough for motor - wheel + position
    // with the position itself outside the play range after contact breaks
    localparam int CALC_W = ((STEP_W > PLAY_W + 1) ? STEP_W : PLAY_W + 1) + 3;

    typedef enum logic [1:0] {
        MODE_LOW  = 2'd0,
        MODE_NONE = 2'd1,
        MODE_HIGH = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAY_MAXIMUM     = 2'd0,
        REG_ACCEL_HYSTERESIS = 2'd1
    } cfg_reg_t;

    // position is signed: leaving contact can put it below zero or above max
    typedef struct packed {
        mode_t                     mode;
        logic signed [CALC_W-1:0]  pos;
        logic signed [STEP_W-1:0]  prev;
        logic signed [STEP_W-1:0]  cws;
    } gbe_state_t;

endpackage

`default_nettype wire

// ----- design/gbe_core.sv -----
// ----------------------------------------------------------------------------
// gbe_core
// next-state and wheel estimate for one motor increment
// ----------------------------------------------------------------------------
`default_nettype none

module gbe_core (
    input  wire gbe_pkg::gbe_state_t                 cur_state,
    input  wire logic signed [gbe_pkg::STEP_W-1:0]   motor_step,
    input  wire logic [gbe_pkg::PLAY_W-1:0]          play_maximum,
    input  wire logic [gbe_pkg::HYST_W-1:0]          accel_hysteresis,
    output gbe_pkg::gbe_state_t                      nxt_state,
    output logic signed [gbe_pkg::WHEEL_W-1:0]       wheel_step,
    output gbe_pkg::mode_t                           contact_mode
);
    import gbe_pkg::*;

    logic signed [CALC_W-1:0] motor_x;
    logic signed [CALC_W-1:0] prev_x;
    logic signed [CALC_W-1:0] cws_x;
    logic signed [CALC_W-1:0] pos_x;
    logic signed [CALC_W-1:0] pmax_x;
    logic signed [CALC_W-1:0] hyst_x;
    logic signed [CALC_W-1:0] accel;
    logic signed [CALC_W-1:0] newpos;
    logic signed [CALC_W-1:0] wheel_x;
    logic                     wheel_ovf;

    assign motor_x = CALC_W'(motor_step);
    assign prev_x  = CALC_W'(cur_state.prev);
    assign cws_x   = CALC_W'(cur_state.cws);
    assign pos_x   = cur_state.pos;
    assign pmax_x  = CALC_W'($signed({1'b0, play_maximum}));
    assign hyst_x  = CALC_W'($signed({1'b0, accel_hysteresis}));
    assign accel   = motor_x - prev_x;
    assign newpos  = motor_x - cws_x + pos_x;

    always_comb begin
        nxt_state      = cur_state;
        nxt_state.prev = motor_step;
        wheel_x        = cws_x;
        case (cur_state.mode)
            MODE_LOW: begin
                if (accel <= hyst_x) begin
                    wheel_x       = motor_x;
                    nxt_state.cws = motor_step;
                    nxt_state.pos = '0;
                end else if (newpos > pmax_x) begin
                    nxt_state.mode = MODE_HIGH;
                    nxt_state.pos  = pmax_x;
                    wheel_x        = motor_x - pmax_x;
                end else begin
                    nxt_state.mode = MODE_NONE;
                    nxt_state.pos  = newpos;
                end
            end
            MODE_NONE: begin
                if (newpos > pmax_x) begin
                    nxt_state.mode = MODE_HIGH;
                    nxt_state.pos  = pmax_x;
                    wheel_x        = motor_x - pmax_x;
                end else if (newpos < 0) begin
                    nxt_state.mode = MODE_LOW;
                    nxt_state.pos  = '0;
                    wheel_x        = motor_x + pmax_x;
                end else begin
                    nxt_state.pos  = newpos;
                end
            end
            MODE_HIGH: begin
                if (accel >= -hyst_x) begin
                    wheel_x       = motor_x;
                    nxt_state.cws = motor_step;
                    nxt_state.pos = pmax_x;
                end else if (newpos < 0) begin
                    nxt_state.mode = MODE_LOW;
                    nxt_state.pos  = '0;
                    wheel_x        = motor_x + pmax_x;
                end else begin
                    nxt_state.mode = MODE_NONE;
                    nxt_state.pos  = newpos;
                end
            end
            default: begin
                // unused code: start over out of contact, history cleared
                nxt_state.mode = MODE_NONE;
                nxt_state.pos  = pmax_x >>> 1;
                nxt_state.prev = '0;
                nxt_state.cws  = '0;
                wheel_x        = '0;
            end
        endcase
    end

    // saturate to the wheel field
    assign wheel_ovf = (wheel_x[CALC_W-1:WHEEL_W-1]
                        != {(CALC_W - WHEEL_W + 1){wheel_x[CALC_W-1]}});

    always_comb begin
        if (wheel_ovf) begin
            wheel_step = wheel_x[CALC_W-1] ? {1'b1, {STEP_W{1'b0}}}
                                           : {1'b0, {STEP_W{1'b1}}};
        end else begin
            wheel_step = wheel_x[WHEEL_W-1:0];
        end
    end

    assign contact_mode = nxt_state.mode;

endmodule

`default_nettype wire

// ----- design/gear_backlash_estimator.sv -----
// ----------------------------------------------------------------------------
// gear_backlash_estimator
// estimates the wheel increment seen through gear backlash from the motor
// increment of each control period
// ----------------------------------------------------------------------------
// Each accepted motor increment yields exactly one result: it is held in the
// input register, then the contact logic updates the state and loads the
// result register. One item is taken every cycle while the output side is
// not stalled; the state loop (contact mode, play position, history) closes
// through the combinational contact logic. Writing either configuration
// register puts the block back out of contact with the play position at
// half the maximum and the history cleared; write only while no item is in
// flight.
`default_nettype none

module gear_backlash_estimator (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input items
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [gbe_pkg::STEP_W-1:0]   s_motor_step,
    // result items
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [gbe_pkg::WHEEL_W-1:0]       m_wheel_step,
    output logic [1:0]                               m_contact_mode,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [gbe_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [gbe_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gbe_pkg::*;

    logic [PLAY_W-1:0]         play_max_reg;
    logic [HYST_W-1:0]         hyst_reg;
    gbe_state_t                state_reg;
    gbe_state_t                state_next;
    logic                      in_valid_reg;
    logic signed [STEP_W-1:0]  in_motor_reg;
    logic                      out_valid_reg;
    logic signed [WHEEL_W-1:0] out_wheel_reg;
    mode_t                     out_mode_reg;
    logic signed [WHEEL_W-1:0] wheel_next;
    mode_t                     mode_next;
    logic                      advance;
    logic                      cfg_hit;
    logic [PLAY_W-1:0]         new_play_max;

    gbe_core u_core (
        .cur_state        (state_reg),
        .motor_step       (in_motor_reg),
        .play_maximum     (play_max_reg),
        .accel_hysteresis (hyst_reg),
        .nxt_state        (state_next),
        .wheel_step       (wheel_next),
        .contact_mode     (mode_next)
    );

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && ((cfg_index == REG_PLAY_MAXIMUM)
                                     || (cfg_index == REG_ACCEL_HYSTERESIS));
    assign new_play_max = (cfg_index == REG_PLAY_MAXIMUM) ? cfg_data[PLAY_W-1:0]
                                                          : play_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            play_max_reg   <= '0;
            hyst_reg       <= '0;
            state_reg.mode <= MODE_NONE;
            state_reg.pos  <= '0;
            state_reg.prev <= '0;
            state_reg.cws  <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_hit) begin
                play_max_reg   <= new_play_max;
                if (cfg_index == REG_ACCEL_HYSTERESIS) begin
                    hyst_reg <= cfg_data[HYST_W-1:0];
                end
                state_reg.mode <= MODE_NONE;
                state_reg.pos  <= CALC_W'(new_play_max >> 1);
                state_reg.prev <= '0;
                state_reg.cws  <= '0;
            end else if (advance) begin
                state_reg <= state_next;
            end
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_motor_reg <= s_motor_step;
        end
        if (advance) begin
            out_wheel_reg <= wheel_next;
            out_mode_reg  <= mode_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_wheel_step   = out_wheel_reg;
    assign m_contact_mode = out_mode_reg;

    // in low contact the play sits at zero, in high contact at the maximum
    a_low_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_LOW) |-> (state_reg.pos == '0))
        else $error("low contact with nonzero play position");

    a_high_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_HIGH) |-> (state_reg.pos == CALC_W'(play_max_reg)))
        else $error("high contact away from play maximum");

    a_mode_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.mode == MODE_LOW) || (state_reg.mode == MODE_NONE)
        || (state_reg.mode == MODE_HIGH))
        else $error("contact state holds the unused code");

    a_cfg_reinit: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> (state_reg.mode == MODE_NONE) && (state_reg.prev == '0)
                    && (state_reg.cws == '0))
        else $error("configuration write did not reinitialise the state");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("computed item missing at the output");

endmodule

`default_nettype wire
